### design/bsp_point_locate_unit_assert.svh
// assertion macros for the bsp point locate unit and its checker
// no dependencies; included by the checker file
`ifndef BSP_POINT_LOCATE_UNIT_ASSERT_SVH
`define BSP_POINT_LOCATE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define BPL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define BPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bpl_pkg.sv
// shared constants and node entry layout for the bsp point locate unit
// no dependencies
package bpl_pkg;

  // node table geometry (power-of-two depth, slot is the low id bits)
  localparam int NODE_COUNT = 4096;
  localparam int NODE_AW    = $clog2(NODE_COUNT);

  // walk limit in node reads
  localparam int MAX_STEPS  = 64;
  localparam int STEP_W     = $clog2(MAX_STEPS + 1);

  // child ids at or above this value are subsector leaves
  localparam logic [15:0] LEAF_MARK = 16'd32768;

  // input opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // one node table entry
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic        [15:0] front;
    logic        [15:0] back;
  } node_t;

endpackage

### design/bsp_point_locate_unit.sv
// bsp point locate unit: node table memory and tree walk sequencer
// depends on bpl_pkg
//
//  channel | ports                     | transfer
//  --------+---------------------------+-----------------------------------
//  input   | start, busy, in_*         | start high while busy low
//  result  | out_valid, out_*          | one cycle per result, no stall
//  config  | cfg_valid, cfg_ready, cfg_data | cfg_valid and cfg_ready high
//
// a load writes the node table in its transfer cycle.
// a query whose root is a leaf gives its result the next cycle, without busy.
// otherwise each node read is taken through S_MUL (product multiply on the
// table read) and then S_DEC (compare and next read), and the result is
// registered from the last S_DEC; the step limit caps a walk at MAX_STEPS node reads.
// synchronous active-low reset clears control state; the table is not cleared.
module bsp_point_locate_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_opcode,
  input  logic [11:0]         in_node_index,
  input  logic signed [15:0]  in_line_x,
  input  logic signed [15:0]  in_line_y,
  input  logic signed [15:0]  in_line_dx,
  input  logic signed [15:0]  in_line_dy,
  input  logic [15:0]         in_front_child,
  input  logic [15:0]         in_back_child,
  input  logic signed [15:0]  in_point_x,
  input  logic signed [15:0]  in_point_y,
  output logic                out_valid,
  output logic [14:0]         out_subsector,
  output logic                out_walk_overflow,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import bpl_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DEC} state_t;

  state_t              state_r;
  logic [15:0]         root_r;
  logic signed [15:0]  px_r, py_r;
  logic [STEP_W-1:0]   steps_r;
  logic signed [31:0]  prod_a_r, prod_b_r;
  logic                out_valid_r;
  logic [14:0]         out_sub_r;
  logic                out_ovf_r;

  // node table memory
  node_t               mem [NODE_COUNT];
  node_t               rd_q;
  node_t               wr_node;
  logic                mem_we, mem_re;
  logic [NODE_AW-1:0]  mem_raddr;

  logic                accept;
  logic                root_leaf;
  logic signed [15:0]  ox, oy;
  logic signed [32:0]  cross_prod;
  logic [15:0]         child;
  logic                child_leaf;
  logic                limit_hit;
  logic [15:0]         leaf_off;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign root_leaf = (root_r >= LEAF_MARK);

  // load entry assembled from the input fields
  assign wr_node = '{x: in_line_x, y: in_line_y, dx: in_line_dx, dy: in_line_dy,
                     front: in_front_child, back: in_back_child};
  assign mem_we  = accept && (in_opcode == OP_LOAD);

  // offsets wrap to 16 bits, then the two products of the cross term
  assign ox = px_r - rd_q.x;
  assign oy = py_r - rd_q.y;

  // side decision and child choice
  assign cross_prod = 33'(prod_a_r) - 33'(prod_b_r);
  assign child      = (cross_prod <= 0) ? rd_q.back : rd_q.front;
  assign child_leaf = (child >= LEAF_MARK);
  assign limit_hit  = (steps_r >= STEP_W'(MAX_STEPS));

  // read port control: root on transfer, child while walking
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = root_r[NODE_AW-1:0];
    leaf_off  = '0;
    unique case (state_r)
      S_IDLE: begin
        mem_re    = accept && (in_opcode == OP_QUERY) && !root_leaf;
        mem_raddr = root_r[NODE_AW-1:0];
        leaf_off  = root_r - LEAF_MARK;
      end
      S_MUL: begin
        mem_re = 1'b0;
      end
      S_DEC: begin
        mem_re    = !child_leaf && !limit_hit;
        mem_raddr = child[NODE_AW-1:0];
        leaf_off  = child - LEAF_MARK;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // table write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[in_node_index[NODE_AW-1:0]] <= wr_node;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  // root register write transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      root_r <= cfg_data;
    end
  end

  // walk sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      steps_r     <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_opcode == OP_QUERY)) begin
            px_r <= in_point_x;
            py_r <= in_point_y;
            if (root_leaf) begin
              out_valid_r <= 1'b1;
              out_sub_r   <= leaf_off[14:0];
              out_ovf_r   <= 1'b0;
            end else begin
              steps_r <= STEP_W'(1);
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_a_r <= ox * rd_q.dy;
          prod_b_r <= oy * rd_q.dx;
          state_r  <= S_DEC;
        end
        S_DEC: begin
          if (child_leaf) begin
            out_valid_r <= 1'b1;
            out_sub_r   <= leaf_off[14:0];
            out_ovf_r   <= 1'b0;
            state_r     <= S_IDLE;
          end else if (limit_hit) begin
            out_valid_r <= 1'b1;
            out_sub_r   <= '0;
            out_ovf_r   <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            steps_r <= steps_r + STEP_W'(1);
            state_r <= S_MUL;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_subsector     = out_sub_r;
  assign out_walk_overflow = out_ovf_r;

endmodule

### design/bpl_checker.sv
// port-level checker for the bsp point locate unit, with its bind
// depends on bsp_point_locate_unit_assert.svh
`include "bsp_point_locate_unit_assert.svh"

module bpl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_opcode,
  input logic        out_valid,
  input logic [14:0] out_subsector,
  input logic        out_walk_overflow
);

  // an overflow result carries subsector zero
  `BPL_ASSERT_IMPLY(a_ovf_zero, clk, rst_n, out_valid && out_walk_overflow, out_subsector == 15'd0, "overflow result with nonzero subsector")

  // a load transfer never yields a result on the next cycle
  `BPL_ASSERT_NEXT(a_load_silent, clk, rst_n, start && !busy && !in_opcode, !out_valid, "result after load transfer")

  // a walk always ends with a result
  `BPL_ASSERT_IMPLY(a_walk_ends, clk, rst_n, $fell(busy) && $past(rst_n), out_valid, "walk ended without a result")

  // a result right after an idle cycle comes from a leaf root, never an overflow
  `BPL_ASSERT_IMPLY(a_root_leaf, clk, rst_n, out_valid && !$past(busy) && $past(rst_n), !out_walk_overflow, "overflow without a walk")

endmodule

bind bsp_point_locate_unit bpl_checker u_bpl_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_opcode         (in_opcode),
  .out_valid         (out_valid),
  .out_subsector     (out_subsector),
  .out_walk_overflow (out_walk_overflow)
);

### tb/sv/bsp_point_locate_unit_checker.sv
// result checker for the bsp point locate unit: tracks node loads and root writes,
// walks its own copy of the tree per query and compares every result transfer
// depends on bpl_pkg
module bsp_point_locate_unit_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_opcode,
  input  logic [11:0]        in_node_index,
  input  logic signed [15:0] in_line_x,
  input  logic signed [15:0] in_line_y,
  input  logic signed [15:0] in_line_dx,
  input  logic signed [15:0] in_line_dy,
  input  logic [15:0]        in_front_child,
  input  logic [15:0]        in_back_child,
  input  logic signed [15:0] in_point_x,
  input  logic signed [15:0] in_point_y,
  input  logic               out_valid,
  input  logic [14:0]        out_subsector,
  input  logic               out_walk_overflow,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  import bpl_pkg::*;

  typedef struct packed {
    logic [14:0] subsector;
    logic        walk_overflow;
  } locate_t;

  node_t       node_tbl [NODE_COUNT];
  logic [15:0] root_id;
  locate_t     expected_locs [$];
  int          mismatches = 0;

  // walk from the root until a leaf id or the step limit
  function automatic locate_t walk_tree(input logic signed [15:0] px,
                                        input logic signed [15:0] py);
    locate_t            loc;
    logic [15:0]        id;
    int                 steps;
    node_t              nd;
    logic signed [15:0] ox, oy, ldx, ldy;
    longint             cross_prod;
    loc.subsector     = '0;
    loc.walk_overflow = 1'b0;
    id    = root_id;
    steps = 0;
    while (id < LEAF_MARK) begin
      if (steps >= MAX_STEPS) begin
        loc.walk_overflow = 1'b1;
        return loc;
      end
      nd  = node_tbl[id[NODE_AW-1:0]];
      // offsets wrap to 16 bits, the product is exact
      ox  = px - nd.x;
      oy  = py - nd.y;
      ldx = nd.dx;
      ldy = nd.dy;
      cross_prod = longint'(ox) * longint'(ldy) - longint'(oy) * longint'(ldx);
      id         = (cross_prod <= 0) ? nd.back : nd.front;
      steps++;
    end
    loc.subsector = id[14:0];
    return loc;
  endfunction

  always @(posedge clk) begin
    locate_t want;
    if (!rst_n) begin
      root_id = '0;
      expected_locs.delete();
    end else begin
      // result transfer against the oldest expected location
      if (out_valid) begin
        if (expected_locs.size() == 0) begin
          if (mismatches < 10)
            $display("checker: unexpected result subsector %0d overflow %0b",
                     out_subsector, out_walk_overflow);
          mismatches++;
        end else begin
          want = expected_locs.pop_front();
          if (out_subsector !== want.subsector ||
              out_walk_overflow !== want.walk_overflow) begin
            if (mismatches < 10)
              $display("checker: mismatch subsector exp %0d got %0d, overflow exp %0b got %0b",
                       want.subsector, out_subsector, want.walk_overflow,
                       out_walk_overflow);
            mismatches++;
          end
        end
      end
      // root register write
      if (cfg_valid && cfg_ready)
        root_id = cfg_data;
      // input transfer: store a node or predict a walk
      if (start && !busy) begin
        if (in_opcode == OP_LOAD)
          node_tbl[in_node_index] = '{x: in_line_x, y: in_line_y, dx: in_line_dx,
                                      dy: in_line_dy, front: in_front_child,
                                      back: in_back_child};
        else
          expected_locs.push_back(walk_tree(in_point_x, in_point_y));
      end
    end
    pending    <= expected_locs.size();
    fail_count <= mismatches;
  end

endmodule

### tb/sv/testbench.sv
// top of the bsp point locate unit testbench: clock, reset, node loads, queries
// and root writes, with the verdict; depends on bpl_pkg, the unit and its checker
module testbench;
  import bpl_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int ITEMS_PER_PHASE = 380;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_opcode;
  logic [11:0]        in_node_index;
  logic signed [15:0] in_line_x;
  logic signed [15:0] in_line_y;
  logic signed [15:0] in_line_dx;
  logic signed [15:0] in_line_dy;
  logic [15:0]        in_front_child;
  logic [15:0]        in_back_child;
  logic signed [15:0] in_point_x;
  logic signed [15:0] in_point_y;
  logic               out_valid;
  logic [14:0]        out_subsector;
  logic               out_walk_overflow;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [15:0]        cfg_data;
  int                 fail_count;
  int                 pending;

  // stimulus bookkeeping: walks may only reach loaded slots
  bit          slot_loaded [NODE_COUNT];
  logic [11:0] loaded_slots [$];
  logic [11:0] recent_slots [$];
  logic [15:0] root_now;
  int          idle_pct;
  int          items_sent;

  bsp_point_locate_unit DUT (.*);

  bsp_point_locate_unit_checker checker_inst (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic signed [15:0] rand_coord();
    return 16'($urandom());
  endfunction

  function automatic logic [15:0] leaf_id();
    return LEAF_MARK | 16'($urandom_range(0, 32767));
  endfunction

  // upper id bits alias onto the same table slot
  function automatic logic [15:0] node_id(input logic [11:0] slot);
    return {1'b0, 3'($urandom_range(0, 7)), slot};
  endfunction

  // recent slots first so chains grow deep
  function automatic logic [15:0] pick_child();
    int roll;
    roll = $urandom_range(0, 99);
    if (loaded_slots.size() == 0 || roll < 30)
      return leaf_id();
    if (roll < 75)
      return node_id(recent_slots[$urandom_range(0, recent_slots.size() - 1)]);
    return node_id(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
  endfunction

  function automatic logic [11:0] pick_slot();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25 && root_now < LEAF_MARK)
      return root_now[11:0];
    if (roll < 90)
      return 12'($urandom_range(0, 63));
    return 12'($urandom_range(0, NODE_COUNT - 1));
  endfunction

  function automatic logic [15:0] pick_root();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5)
      return 16'hFFFF;
    if (roll < 10)
      return LEAF_MARK;
    if (roll < 25 || loaded_slots.size() == 0)
      return leaf_id();
    return node_id(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
  endfunction

  // one input transfer, with an optional gap before it
  task automatic transfer_item(input logic op, input logic [11:0] idx,
                               input logic [15:0] lx, input logic [15:0] ly,
                               input logic [15:0] ldx, input logic [15:0] ldy,
                               input logic [15:0] fr, input logic [15:0] bk,
                               input logic [15:0] px, input logic [15:0] py);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3))
        @(posedge clk);
    end
    start          <= 1'b1;
    in_opcode      <= op;
    in_node_index  <= idx;
    in_line_x      <= lx;
    in_line_y      <= ly;
    in_line_dx     <= ldx;
    in_line_dy     <= ldy;
    in_front_child <= fr;
    in_back_child  <= bk;
    in_point_x     <= px;
    in_point_y     <= py;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic load_node(input logic [11:0] slot, input logic [15:0] lx,
                           input logic [15:0] ly, input logic [15:0] ldx,
                           input logic [15:0] ldy, input logic [15:0] fr,
                           input logic [15:0] bk);
    if (!slot_loaded[slot]) begin
      slot_loaded[slot] = 1'b1;
      loaded_slots.push_back(slot);
    end
    recent_slots.push_back(slot);
    if (recent_slots.size() > 4)
      void'(recent_slots.pop_front());
    transfer_item(OP_LOAD, slot, lx, ly, ldx, ldy, fr, bk, rand_coord(), rand_coord());
  endtask

  task automatic query_point(input logic [15:0] px, input logic [15:0] py);
    transfer_item(OP_QUERY, 12'($urandom()), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), 16'($urandom()), 16'($urandom()), px, py);
  endtask

  // children are chosen before the slot counts as loaded
  task automatic random_load();
    logic [11:0]        slot;
    logic [15:0]        fr, bk;
    logic signed [15:0] ldx, ldy;
    slot = pick_slot();
    fr   = pick_child();
    bk   = pick_child();
    ldx  = rand_coord();
    ldy  = rand_coord();
    if ($urandom_range(0, 19) == 0) begin
      ldx = '0;
      ldy = '0;
    end
    load_node(slot, rand_coord(), rand_coord(), ldx, ldy, fr, bk);
  endtask

  // root write once every query has answered
  task automatic set_root(input logic [15:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    // a load leaves no result, so let the last one settle
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    root_now = value;
  endtask

  initial begin
    int phase;
    int phase_end;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_opcode      <= OP_LOAD;
    in_node_index  <= '0;
    in_line_x      <= '0;
    in_line_y      <= '0;
    in_line_dx     <= '0;
    in_line_dy     <= '0;
    in_front_child <= '0;
    in_back_child  <= '0;
    in_point_x     <= '0;
    in_point_y     <= '0;
    cfg_valid      <= 1'b0;
    cfg_data       <= '0;
    idle_pct   = 0;
    items_sent = 0;
    root_now   = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // root is itself a leaf, highest and lowest subsector
    set_root(16'hFFFF);
    query_point(16'sh8000, 16'sh7FFF);
    set_root(LEAF_MARK);
    query_point(16'sh7FFF, 16'sh8000);

    // horizontal line, extreme node, aliased self loop, vertical line, zero direction
    load_node(12'd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, LEAF_MARK | 16'd1, LEAF_MARK | 16'd2);
    load_node(12'd4095, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'hFFFF, LEAF_MARK);
    load_node(12'd1, 16'sd100, -16'sd100, 16'sd7, -16'sd3, 16'h1001, 16'h0001);
    load_node(12'd2, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'h7000, 16'h0FFF);
    load_node(12'd3, 16'sd5, 16'sd5, 16'sd0, 16'sd0, LEAF_MARK | 16'd3, LEAF_MARK | 16'd4);

    // two-level walks, zero cross product and offset wrap
    set_root(16'd2);
    query_point(16'sd5, -16'sd1);
    query_point(16'sd5, 16'sd9);
    query_point(16'sd0, 16'sd0);
    query_point(16'sh8000, 16'sh7FFF);
    query_point(16'sh7FFF, 16'sh8000);

    // highest non-leaf root id
    set_root(16'h7FFF);
    query_point(16'sh7FFF, 16'sh8000);
    query_point(16'sh8000, 16'sh7FFF);

    // endless loop runs into the step limit
    set_root(16'd1);
    query_point(16'sd0, 16'sd0);
    query_point(16'sh7FFF, 16'sh7FFF);

    // degenerate line always goes back
    set_root(16'd3);
    query_point(16'sd1234, -16'sd4321);

    // random trees: busy sender, quiet sender, back to back
    for (phase = 0; phase < 3; phase++) begin
      idle_pct  = (phase == 0) ? 15 : (phase == 1) ? 72 : 0;
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) begin
        set_root(pick_root());
        repeat ($urandom_range(4, 8)) begin
          repeat ($urandom_range(0, 5)) random_load();
          repeat ($urandom_range(1, 6)) query_point(rand_coord(), rand_coord());
        end
      end
    end

    // drain: wait until every query has answered
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (140) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("PASS bsp_point_locate_unit");
    else
      $display("FAIL bsp_point_locate_unit");
    $finish;
  end

  // run limit
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL bsp_point_locate_unit");
    $finish;
  end

endmodule

### bsp_point_locate_unit.f
+incdir+design
design/bpl_pkg.sv
design/bsp_point_locate_unit.sv
design/bpl_checker.sv
tb/sv/bsp_point_locate_unit_checker.sv
tb/sv/testbench.sv
